// ----- sv/string_intern_table_defines.svh -----
// ---------------------------------------------------------------------------
// String intern table: assertion macros
// Shared property forms used by the lookup engine.
// ---------------------------------------------------------------------------
`ifndef STRING_INTERN_TABLE_DEFINES_SVH
`define STRING_INTERN_TABLE_DEFINES_SVH

// condition holds on every clock edge outside reset
`define SIT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sit_pkg.sv -----
// ---------------------------------------------------------------------------
// String intern table package
// Hash constants, FNV-1a step, result codes, controller states, shared structs.
// ---------------------------------------------------------------------------
package sit_pkg;

   localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
   localparam int OFFSET_W    = 17;
   localparam int STATUS_W    = 3;
   localparam int RSP_TDATA_W = ((OFFSET_W + 7) / 8) * 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND      = 3'd0,
      ST_INSERTED   = 3'd1,
      ST_GROW_FAIL  = 3'd2,
      ST_ARENA_FULL = 3'd3,
      ST_TOO_LONG   = 3'd4,
      ST_TABLE_FULL = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_CMP,
      S_ALLOC,
      S_COPY,
      S_LOAD,
      S_GCLR,
      S_GREAD,
      S_GCHK,
      S_GPROBE,
      S_FINISH
   } eng_state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] hash;
   } key_done_type;

   typedef struct packed {
      logic                valid;
      logic [OFFSET_W-1:0] offset;
      status_type          status;
   } result_type;

   // one FNV-1a round; prime is 2^40 + 0x1b3, so shifts and adds only
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// ----- sv/sit_key_cap.sv -----
// ---------------------------------------------------------------------------
// String intern table: key capture
// Folds key bytes into the running hash, counts them and buffers them.
// ---------------------------------------------------------------------------
module sit_key_cap import sit_pkg::*; #(
   parameter int  MAX_KEY_LEN = 64,
   localparam int LW  = $clog2(MAX_KEY_LEN + 2),
   localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           acc,
   input  logic [7:0]     key_byte,
   input  logic           has_byte,
   input  logic           key_last,
   input  logic [KAW-1:0] kb_raddr,
   output logic [7:0]     kb_rdata,
   output key_done_type   key,
   output logic [LW-1:0]  key_len
);

   logic [63:0]   hash_ff, hash_in, hash_b;
   logic [LW-1:0] cnt_ff, cnt_in, cnt_b;
   logic          start_ff, start_in;
   logic [63:0]   fin_hash_ff, fin_hash_in;
   logic [LW-1:0] fin_len_ff, fin_len_in;
   logic [7:0]    kbuf [0:MAX_KEY_LEN-1];
   logic [7:0]    kb_rdata_ff;
   logic          room;

   assign room = (cnt_ff < LW'(MAX_KEY_LEN));

   always_comb begin
      hash_b      = has_byte ? fnv_step(hash_ff, key_byte) : hash_ff;
      cnt_b       = cnt_ff;
      if (has_byte) begin
         cnt_b = room ? cnt_ff + LW'(1) : LW'(MAX_KEY_LEN + 1);
      end
      hash_in     = hash_ff;
      cnt_in      = cnt_ff;
      start_in    = 1'b0;
      fin_hash_in = fin_hash_ff;
      fin_len_in  = fin_len_ff;
      if (acc && key_last) begin
         hash_in     = HASH_BASIS;
         cnt_in      = '0;
         start_in    = 1'b1;
         fin_hash_in = hash_b;
         fin_len_in  = cnt_b;
      end else if (acc) begin
         hash_in = hash_b;
         cnt_in  = cnt_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= HASH_BASIS;
         cnt_ff   <= '0;
         start_ff <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         cnt_ff   <= cnt_in;
         start_ff <= start_in;
      end
      fin_hash_ff <= fin_hash_in;
      fin_len_ff  <= fin_len_in;
   end

   always_ff @(posedge clock) begin
      if (acc && has_byte && room) begin
         kbuf[cnt_ff[KAW-1:0]] <= key_byte;
      end
      kb_rdata_ff <= kbuf[kb_raddr];
   end

   assign kb_rdata  = kb_rdata_ff;
   assign key.start = start_ff;
   assign key.hash  = fin_hash_ff;
   assign key_len   = fin_len_ff;

endmodule

// ----- sv/sit_engine.sv -----
// ---------------------------------------------------------------------------
// String intern table: lookup engine
// Slot table and byte arena memories with the probe, insert and rehash
// sequencer.
// ---------------------------------------------------------------------------
`include "string_intern_table_defines.svh"

module sit_engine import sit_pkg::*; #(
   parameter int  MAX_SLOTS     = 1024,
   parameter int  INITIAL_SLOTS = 64,
   parameter int  ARENA_BYTES   = 65536,
   parameter int  MAX_KEY_LEN   = 64,
   localparam int LW  = $clog2(MAX_KEY_LEN + 2),
   localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  key_done_type   key,
   input  logic [LW-1:0]  key_len,
   output logic [KAW-1:0] kb_raddr,
   input  logic [7:0]     kb_rdata,
   input  logic           out_free,
   output result_type     res,
   output logic           idle
);

   localparam int SIW       = $clog2(MAX_SLOTS);
   localparam int CW        = $clog2(MAX_SLOTS + 1);
   localparam int FW        = $clog2(ARENA_BYTES + 1);
   localparam int AW        = $clog2(ARENA_BYTES);
   localparam int SW        = ((FW > LW) ? FW : LW) + 1;
   localparam int EW        = 64 + FW + LW;
   localparam int LDW       = CW + 4;
   localparam int InitLog   = $clog2(INITIAL_SLOTS);
   localparam int InitSlots = ((1 << InitLog) < MAX_SLOTS) ? (1 << InitLog) : MAX_SLOTS;

   eng_state_type        state_ff, state_in;
   logic [63:0]          h_ff, h_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [SIW-1:0]       j_ff, j_in;
   logic [CW-1:0]        tries_ff, tries_in;
   logic [LW-1:0]        k_ff, k_in;
   logic [FW-1:0]        off_ff, off_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [EW-1:0]        ge_ff, ge_in;
   logic [CW-1:0]        n_ff, n_in;
   logic                 bank_ff, bank_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        count_ff, count_in;
   status_type           status_ff, status_in;
   logic [OFFSET_W-1:0]  res_off_ff, res_off_in;

   logic [EW-1:0]        slot_mem [0:(2**(SIW+1))-1];
   logic [EW-1:0]        s_rdata_ff;
   logic [SIW:0]         s_raddr, s_waddr;
   logic                 s_we;
   logic [EW-1:0]        s_wdata;

   logic [7:0]           arena_mem [0:ARENA_BYTES-1];
   logic [7:0]           a_rdata_ff;
   logic [AW-1:0]        a_raddr, a_waddr;
   logic                 a_we;

   logic [63:0]          e_hash;
   logic [FW-1:0]        e_off;
   logic [LW-1:0]        e_len;
   logic [SIW-1:0]       mask, nmask, j_next, jj;
   logic [LW-1:0]        k1;
   logic [AW-1:0]        addr_k, addr_k1;
   logic [63:0]          hs;
   logic                 last_i;

   assign e_hash  = s_rdata_ff[EW-1 -: 64];
   assign e_off   = s_rdata_ff[LW +: FW];
   assign e_len   = s_rdata_ff[LW-1:0];
   assign mask    = SIW'(n_ff - CW'(1));
   assign nmask   = SIW'((n_ff << 1) - CW'(1));
   assign j_next  = (j_ff + SIW'(1)) & mask;
   assign k1      = k_ff + LW'(1);
   assign addr_k  = AW'(SW'(off_ff) + SW'(k_ff));
   assign addr_k1 = AW'(SW'(off_ff) + SW'(k1));
   assign hs      = (key.hash == 64'd0) ? 64'd1 : key.hash;
   assign last_i  = ((i_ff + CW'(1)) == n_ff);

   always_comb begin
      state_in   = state_ff;
      h_in       = h_ff;
      len_in     = len_ff;
      j_in       = j_ff;
      tries_in   = tries_ff;
      k_in       = k_ff;
      off_in     = off_ff;
      i_in       = i_ff;
      ge_in      = ge_ff;
      n_in       = n_ff;
      bank_in    = bank_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      res_off_in = res_off_ff;
      s_raddr    = '0;
      s_we       = 1'b0;
      s_waddr    = '0;
      s_wdata    = '0;
      a_raddr    = '0;
      a_we       = 1'b0;
      a_waddr    = addr_k;
      kb_raddr   = k_ff[KAW-1:0];
      res        = '0;
      idle       = 1'b0;
      jj         = (e_hash[SIW-1:0] & nmask);

      case (state_ff)
         S_CLEAR: begin
            s_we    = 1'b1;
            s_waddr = {1'b0, i_ff[SIW-1:0]};
            if (i_ff == CW'(InitSlots - 1)) begin
               i_in     = '0;
               state_in = S_IDLE;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         S_IDLE: begin
            idle = 1'b1;
            if (key.start) begin
               h_in       = hs;
               len_in     = key_len;
               tries_in   = '0;
               res_off_in = '0;
               if (key_len > LW'(MAX_KEY_LEN)) begin
                  status_in = ST_TOO_LONG;
                  state_in  = S_FINISH;
               end else begin
                  j_in     = hs[SIW-1:0] & mask;
                  s_raddr  = {bank_ff, hs[SIW-1:0] & mask};
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE, S_CMP: begin
            // shared fall-through: move on to the next slot of the probe run
            if ((tries_ff + CW'(1)) == n_ff) begin
               status_in = ST_TABLE_FULL;
               state_in  = S_FINISH;
            end else begin
               tries_in = tries_ff + CW'(1);
               j_in     = j_next;
               s_raddr  = {bank_ff, j_next};
               state_in = S_PROBE;
            end
            if (state_ff == S_PROBE) begin
               if (e_hash == 64'd0) begin
                  status_in = status_ff;
                  tries_in  = tries_ff;
                  j_in      = j_ff;
                  state_in  = S_ALLOC;
               end else if (e_hash == h_ff && e_len == len_ff) begin
                  tries_in = tries_ff;
                  j_in     = j_ff;
                  if (len_ff == '0) begin
                     status_in  = ST_FOUND;
                     res_off_in = OFFSET_W'(e_off);
                     state_in   = S_FINISH;
                  end else begin
                     status_in = status_ff;
                     off_in    = e_off;
                     k_in      = '0;
                     a_raddr   = AW'(e_off);
                     kb_raddr  = '0;
                     state_in  = S_CMP;
                  end
               end
            end else if (a_rdata_ff == kb_rdata) begin
               tries_in  = tries_ff;
               j_in      = j_ff;
               status_in = status_ff;
               if (k1 == len_ff) begin
                  status_in  = ST_FOUND;
                  res_off_in = OFFSET_W'(off_ff);
                  state_in   = S_FINISH;
               end else begin
                  k_in     = k1;
                  a_raddr  = addr_k1;
                  kb_raddr = k1[KAW-1:0];
                  state_in = S_CMP;
               end
            end
         end
         S_ALLOC: begin
            if ((SW'(fill_ff) + SW'(len_ff)) > SW'(ARENA_BYTES)) begin
               status_in = ST_ARENA_FULL;
               state_in  = S_FINISH;
            end else begin
               off_in = fill_ff;
               k_in   = '0;
               if (len_ff == '0) begin
                  s_we     = 1'b1;
                  s_waddr  = {bank_ff, j_ff};
                  s_wdata  = {h_ff, fill_ff, len_ff};
                  count_in = count_ff + CW'(1);
                  state_in = S_LOAD;
               end else begin
                  kb_raddr = '0;
                  state_in = S_COPY;
               end
            end
         end
         S_COPY: begin
            a_we = 1'b1;
            if (k1 == len_ff) begin
               s_we     = 1'b1;
               s_waddr  = {bank_ff, j_ff};
               s_wdata  = {h_ff, off_ff, len_ff};
               fill_in  = FW'(SW'(off_ff) + SW'(len_ff));
               count_in = count_ff + CW'(1);
               state_in = S_LOAD;
            end else begin
               k_in     = k1;
               kb_raddr = k1[KAW-1:0];
            end
         end
         S_LOAD: begin
            if ((LDW'(count_ff) * LDW'(10)) >= (LDW'(n_ff) * LDW'(7))) begin
               if (((CW+1)'(n_ff) << 1) <= (CW+1)'(MAX_SLOTS)) begin
                  i_in     = '0;
                  state_in = S_GCLR;
               end else begin
                  status_in  = ST_GROW_FAIL;
                  res_off_in = '0;
                  state_in   = S_FINISH;
               end
            end else begin
               status_in  = ST_INSERTED;
               res_off_in = OFFSET_W'(off_ff);
               state_in   = S_FINISH;
            end
         end
         S_GCLR: begin
            s_we    = 1'b1;
            s_waddr = {~bank_ff, i_ff[SIW-1:0]};
            if ((i_ff + CW'(1)) == CW'(n_ff << 1)) begin
               i_in     = '0;
               state_in = S_GREAD;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         S_GREAD: begin
            s_raddr  = {bank_ff, i_ff[SIW-1:0]};
            state_in = S_GCHK;
         end
         S_GCHK, S_GPROBE: begin
            if (state_ff == S_GCHK && e_hash != 64'd0) begin
               ge_in    = s_rdata_ff;
               j_in     = jj;
               s_raddr  = {~bank_ff, jj};
               state_in = S_GPROBE;
            end else if (state_ff == S_GPROBE && e_hash != 64'd0) begin
               j_in     = (j_ff + SIW'(1)) & nmask;
               s_raddr  = {~bank_ff, (j_ff + SIW'(1)) & nmask};
            end else begin
               if (state_ff == S_GPROBE) begin
                  s_we    = 1'b1;
                  s_waddr = {~bank_ff, j_ff};
                  s_wdata = ge_ff;
               end
               if (last_i) begin
                  bank_in    = ~bank_ff;
                  n_in       = n_ff << 1;
                  status_in  = ST_INSERTED;
                  res_off_in = OFFSET_W'(off_ff);
                  state_in   = S_FINISH;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = S_GREAD;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               res.valid  = 1'b1;
               res.offset = res_off_ff;
               res.status = status_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         i_ff     <= '0;
         n_ff     <= CW'(InitSlots);
         bank_ff  <= 1'b0;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         n_ff     <= n_in;
         bank_ff  <= bank_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
      h_ff       <= h_in;
      len_ff     <= len_in;
      j_ff       <= j_in;
      tries_ff   <= tries_in;
      k_ff       <= k_in;
      off_ff     <= off_in;
      ge_ff      <= ge_in;
      status_ff  <= status_in;
      res_off_ff <= res_off_in;
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         slot_mem[s_waddr] <= s_wdata;
      end
      s_rdata_ff <= slot_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         arena_mem[a_waddr] <= kb_rdata;
      end
      a_rdata_ff <= arena_mem[a_raddr];
   end

   `SIT_ASSERT_ALWAYS(a_count_le_slots, clock, reset, count_ff <= n_ff, "entry count above table size")
   `SIT_ASSERT_ALWAYS(a_fill_in_range, clock, reset, fill_ff <= FW'(ARENA_BYTES), "arena fill overrun")
   `SIT_ASSERT_NEXT(a_start_leaves_idle, clock, reset, key.start && state_ff == S_IDLE, state_ff != S_IDLE, "key end not taken up")

endmodule

// ----- sv/string_intern_table.sv -----
// ---------------------------------------------------------------------------
// String intern table
// Interns byte strings: returns the arena offset of a key, storing it first
// if it is new.
// ---------------------------------------------------------------------------
// Key bytes are taken one per cycle while the engine is idle and folded
// into a 64-bit FNV-1a hash. The item carrying tlast starts the lookup, and
// no further item is taken until it completes: the engine probes one slot
// at a time and compares the stored bytes on a hash and length match; an
// insert copies the key into the arena and then checks the load. When the
// table reaches 70% load it doubles: the new table is cleared, then each old
// slot is read and its entry, if any, moved, probing past collisions. All of
// this is bound by the single read port of the slot memory. After reset a
// clearing pass over INITIAL_SLOTS slots (rounded up to a power of two,
// capped at MAX_SLOTS) runs before the first item is taken. A finished
// result sits in the output register, so new key bytes flow while it waits.
// ---------------------------------------------------------------------------
module string_intern_table import sit_pkg::*; #(
   parameter int MAX_SLOTS     = 1024,
   parameter int INITIAL_SLOTS = 64,
   parameter int ARENA_BYTES   = 65536,
   parameter int MAX_KEY_LEN   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [7:0] key_byte
   input  logic                   req_tuser,  // [0] has_byte
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [16:0] offset
   output logic [STATUS_W-1:0]    rsp_tuser   // [2:0] status
);

   localparam int LW  = $clog2(MAX_KEY_LEN + 2);
   localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

   key_done_type        key;
   logic [LW-1:0]       key_len;
   logic [KAW-1:0]      kb_raddr;
   logic [7:0]          kb_rdata;
   result_type          res;
   logic                eng_idle;
   logic                acc;
   logic                out_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   status_type          rsp_status_ff, rsp_status_in;

   // a pending key end blocks bytes until the engine has picked it up
   assign req_tready = eng_idle && !key.start;
   assign acc        = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   sit_key_cap #(
      .MAX_KEY_LEN (MAX_KEY_LEN)
   ) u_key_cap (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .key_byte (req_tdata),
      .has_byte (req_tuser),
      .key_last (req_tlast),
      .kb_raddr (kb_raddr),
      .kb_rdata (kb_rdata),
      .key      (key),
      .key_len  (key_len)
   );

   sit_engine #(
      .MAX_SLOTS     (MAX_SLOTS),
      .INITIAL_SLOTS (INITIAL_SLOTS),
      .ARENA_BYTES   (ARENA_BYTES),
      .MAX_KEY_LEN   (MAX_KEY_LEN)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .key      (key),
      .key_len  (key_len),
      .kb_raddr (kb_raddr),
      .kb_rdata (kb_rdata),
      .out_free (out_free),
      .res      (res),
      .idle     (eng_idle)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_status_in = rsp_status_ff;
      if (res.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_off_in    = res.offset;
         rsp_status_in = res.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_off_ff    <= rsp_off_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_off_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- tb/sv/tb_string_intern_table.sv -----
// ---------------------------------------------------------------------------
// String intern table testbench
// Streams keys a byte at a time with random gaps and output stalls. Every
// result is checked against a behavioural model of the hash table, arena and
// growth logic run on accepted items, or a directed item's own expectation.
// ---------------------------------------------------------------------------
module tb_string_intern_table;
   import sit_pkg::*;

   localparam int MAX_SLOTS   = 1024;
   localparam int INIT_LOG    = 6;
   localparam int ARENA_BYTES = 65536;
   localparam int MAX_KEY_LEN = 64;
   localparam logic [63:0] FNV_PRIME = 64'h100000001b3;
   localparam int IDLE_LIMIT  = 20000;

   typedef struct {
      logic [7:0] key_byte;
      logic       has_byte;
      logic       key_last;
      logic       typed;
      logic [16:0] exp_offset;
      status_type exp_status;
   } key_item_type;

   typedef struct {
      logic [16:0] offset;
      status_type  status;
   } intern_result_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [7:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   key_item_type stim_q[$];
   key_item_type cur_item;
   intern_result_type result_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 0;
   bit hold_now = 0;

   // model state
   logic [63:0] hash_acc;
   logic [7:0]  key_buf[MAX_KEY_LEN];
   int          key_len;
   logic [63:0] tbl_hash[MAX_SLOTS];
   int          tbl_off[MAX_SLOTS];
   int          tbl_len[MAX_SLOTS];
   logic [7:0]  arena[ARENA_BYTES];
   int          arena_used;
   int          size_log;
   int          entries;
   logic [63:0] tmp_hash[MAX_SLOTS];
   int          tmp_off[MAX_SLOTS];
   int          tmp_len[MAX_SLOTS];

   string_intern_table dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic model_reset();
      foreach (tbl_hash[i]) tbl_hash[i] = '0;
      arena_used = 0;
      entries = 0;
      size_log = INIT_LOG;
      hash_acc = HASH_BASIS;
      key_len = 0;
   endtask

   task automatic grow_table();
      int old_n, new_n, j, tries;
      old_n = 1 << size_log;
      tmp_hash = tbl_hash;
      tmp_off = tbl_off;
      tmp_len = tbl_len;
      foreach (tbl_hash[i]) tbl_hash[i] = '0;
      size_log++;
      new_n = 1 << size_log;
      for (int i = 0; i < old_n; i++) begin
         if (tmp_hash[i] != 0) begin
            j = int'(tmp_hash[i][31:0]) & (new_n - 1);
            tries = 0;
            while (tbl_hash[j] != 0 && tries < new_n) begin
               j = (j + 1) & (new_n - 1);
               tries++;
            end
            tbl_hash[j] = tmp_hash[i];
            tbl_off[j] = tmp_off[i];
            tbl_len[j] = tmp_len[i];
         end
      end
   endtask

   task automatic lookup_key(output intern_result_type r);
      logic [63:0] h;
      int n, j, tries;
      bit empty_seen, same;
      r.offset = '0;
      h = (hash_acc == 0) ? 64'd1 : hash_acc;
      if (key_len > MAX_KEY_LEN) begin
         r.status = ST_TOO_LONG;
         return;
      end
      n = 1 << size_log;
      j = int'(h[31:0]) & (n - 1);
      empty_seen = 0;
      for (tries = 0; tries < n; tries++) begin
         if (tbl_hash[j] == 0) begin
            empty_seen = 1;
            break;
         end
         if (tbl_hash[j] == h && tbl_len[j] == key_len) begin
            same = 1;
            for (int k = 0; k < key_len; k++)
               if (arena[tbl_off[j] + k] != key_buf[k]) same = 0;
            if (same) begin
               r.offset = 17'(tbl_off[j]);
               r.status = ST_FOUND;
               return;
            end
         end
         j = (j + 1) & (n - 1);
      end
      if (!empty_seen) begin
         r.status = ST_TABLE_FULL;
         return;
      end
      if (arena_used + key_len > ARENA_BYTES) begin
         r.status = ST_ARENA_FULL;
         return;
      end
      for (int k = 0; k < key_len; k++) arena[arena_used + k] = key_buf[k];
      tbl_hash[j] = h;
      tbl_off[j] = arena_used;
      tbl_len[j] = key_len;
      r.offset = 17'(arena_used);
      arena_used += key_len;
      entries++;
      r.status = ST_INSERTED;
      if (entries * 10 >= n * 7) begin
         if (n * 2 <= MAX_SLOTS) grow_table();
         else begin
            r.status = ST_GROW_FAIL;
            r.offset = '0;
         end
      end
   endtask

   task automatic take_item(input key_item_type it);
      intern_result_type r;
      if (it.has_byte) begin
         hash_acc = (hash_acc ^ {56'd0, it.key_byte}) * FNV_PRIME;
         if (key_len < MAX_KEY_LEN) begin
            key_buf[key_len] = it.key_byte;
            key_len++;
         end else key_len = MAX_KEY_LEN + 1;
      end
      if (it.key_last) begin
         lookup_key(r);
         if (it.typed) begin
            r.offset = it.exp_offset;
            r.status = it.exp_status;
         end
         result_q.push_back(r);
         hash_acc = HASH_BASIS;
         key_len = 0;
      end
   endtask

   // accepted items feed the model; accepted results are checked
   always @(posedge clock) begin
      intern_result_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) take_item(cur_item);
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result off=%0d st=%0d", $time,
                        rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               e = result_q.pop_front();
               if (rsp_tdata !== RSP_TDATA_W'(e.offset)) begin
                  $display("%0t: offset expected %0d actual %0d", $time,
                           e.offset, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           e.status, rsp_tuser);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_tready = 1;
      forever begin
         @(posedge clock);
         if (hold_now) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_now = 0;
            rsp_tready <= 1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1;
         end
      end
   end

   function automatic key_item_type mk(logic [7:0] b, logic h, logic l);
      key_item_type it;
      it.key_byte = b;
      it.has_byte = h;
      it.key_last = l;
      it.typed = 0;
      it.exp_offset = '0;
      it.exp_status = ST_FOUND;
      return it;
   endfunction

   function automatic key_item_type mk_typed(logic [7:0] b, logic h, int off,
                                             status_type st);
      key_item_type it;
      it = mk(b, h, 1'b1);
      it.typed = 1;
      it.exp_offset = 17'(off);
      it.exp_status = st;
      return it;
   endfunction

   task automatic push_key(logic [7:0] bytes[$]);
      if (bytes.size() == 0) stim_q.push_back(mk(8'h00, 1'b0, 1'b1));
      foreach (bytes[i]) stim_q.push_back(mk(bytes[i], 1'b1, i == bytes.size() - 1));
   endtask

   initial begin
      key_item_type directed[] = '{
         mk_typed(8'h00, 0, 0, ST_INSERTED),   // empty key, no arena bytes
         mk_typed(8'h41, 1, 0, ST_INSERTED),
         mk_typed(8'h41, 1, 0, ST_FOUND),
         mk(8'h07, 0, 0),                      // ignored item
         mk(8'hff, 1, 0), mk_typed(8'h00, 1, 1, ST_INSERTED),
         mk(8'hff, 1, 0), mk_typed(8'h00, 1, 1, ST_FOUND),
         mk_typed(8'h00, 0, 0, ST_FOUND),
         mk_typed(8'hff, 1, 3, ST_INSERTED),
         mk(8'h80, 1, 0), mk(8'h00, 0, 0), mk(8'h7f, 1, 1)
      };
      logic [7:0] kb[$];
      logic [7:0] pool[40][$];
      int n_items, hold_at, pause_at, tail;
      key_item_type it;

      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      req_tlast = 0;
      cur_item = mk(8'h00, 1'b0, 1'b0);
      model_reset();

      foreach (directed[i]) stim_q.push_back(directed[i]);
      // too long: 65 bytes, then exactly the maximum
      for (int i = 0; i < 64; i++) stim_q.push_back(mk(i[7:0], 1'b1, 1'b0));
      stim_q.push_back(mk_typed(8'h5a, 1, 0, ST_TOO_LONG));
      kb = {};
      for (int i = 0; i < 64; i++) kb.push_back(8'(255 - i));
      push_key(kb);

      // random part: a reused pool of keys so that hits are common
      foreach (pool[p]) begin
         int len;
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                             : $urandom_range(0, 8);
         for (int k = 0; k < len; k++) pool[p].push_back(8'($urandom_range(0, 255)));
      end
      n_items = 0;
      while (n_items < 250) begin
         if ($urandom_range(0, 9) == 0) begin
            stim_q.push_back(mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
            n_items++;
         end else begin
            kb = pool[$urandom_range(0, 39)];
            if ($urandom_range(0, 9) == 0) kb.push_back(8'($urandom_range(0, 255)));
            push_key(kb);
            n_items += (kb.size() == 0) ? 1 : kb.size();
         end
      end
      // many distinct keys: several doublings of the table
      for (int i = 0; i < 200; i++) push_key('{8'hee, 8'(i >> 8), 8'(i)});
      for (int i = 0; i < 20; i++) push_key(pool[$urandom_range(0, 39)]);
      push_key('{8'h01, 8'h02, 8'h03});

      hold_at = stim_q.size() / 8;
      pause_at = stim_q.size() / 4;
      tail = stim_q.size() - 200;

      repeat (10) @(posedge clock);
      reset <= 0;

      foreach (stim_q[i]) begin
         it = stim_q[i];
         if (i == hold_at) hold_now = 1;
         if (i == tail) quiet = 1;
         if (i == pause_at) begin
            req_tvalid <= 0;
            while (result_q.size() != 0) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tdata <= it.key_byte;
         req_tuser <= it.has_byte;
         req_tlast <= it.key_last;
         cur_item <= it;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+sv
sv/sit_pkg.sv
sv/sit_key_cap.sv
sv/sit_engine.sv
sv/string_intern_table.sv
tb/sv/tb_string_intern_table.sv
